// File: hdl/mns_pkg.sv
// Package with the shared types, codes and sizes of the melody note sequencer.
`default_nettype none

package mns_pkg;

    localparam int MAX_MELODIES     = 8;
    localparam int NOTES_PER_MELODY = 256;
    localparam int REST_CODE        = 0;

    localparam int MEL_W   = (MAX_MELODIES > 1) ? $clog2(MAX_MELODIES) : 1;
    localparam int NPOS_W  = $clog2(NOTES_PER_MELODY);
    localparam int ADDR_W  = MEL_W + NPOS_W;
    localparam int DEPTH   = MAX_MELODIES * NOTES_PER_MELODY;
    localparam int LEN_W   = $clog2(NOTES_PER_MELODY + 1);

    // Widths of the item fields.
    localparam int ACTION_W = 3;
    localparam int MIDX_W   = 3;
    localparam int EIDX_W   = 8;
    localparam int CODE_W   = 8;
    localparam int DUR_W    = 8;
    localparam int LENF_W   = 9;
    localparam int PSTATE_W = 2;

    // Widths of the internal counters and registers.
    localparam int MPOS_W  = 4;
    localparam int NOTEP_W = 9;
    localparam int TICK_W  = 18;
    localparam int MCNT_W  = 4;
    localparam int TPU_W   = 10;

    // Configuration port.
    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;

    typedef enum logic [ACTION_W-1:0] {
        ACT_TICK      = 3'd0,
        ACT_PLAY      = 3'd1,
        ACT_STOP      = 3'd2,
        ACT_PAUSE     = 3'd3,
        ACT_RESUME    = 3'd4,
        ACT_WR_NOTE   = 3'd5,
        ACT_WR_LENGTH = 3'd6
    } action_t;

    typedef enum logic [PSTATE_W-1:0] {
        RUN_STOP  = 2'd0,
        RUN_PLAY  = 2'd1,
        RUN_PAUSE = 2'd2
    } run_state_t;

    typedef enum logic [2:0] {
        SEQ_IDLE,
        SEQ_EXEC,
        SEQ_SEEK,
        SEQ_READ,
        SEQ_DONE
    } seq_state_t;

    typedef enum logic {
        REG_MELODY_COUNT   = 1'b0,
        REG_TICKS_PER_UNIT = 1'b1
    } reg_index_t;

endpackage

`default_nettype wire

// File: hdl/mns_if.sv
// Handshake interfaces for the command and result channels of the sequencer.
`default_nettype none

interface mns_cmd_if;
    logic                          valid;
    logic                          ready;
    logic [mns_pkg::ACTION_W-1:0]  action;
    logic [mns_pkg::MIDX_W-1:0]    melody_index;
    logic [mns_pkg::EIDX_W-1:0]    entry_index;
    logic [mns_pkg::CODE_W-1:0]    note_code;
    logic [mns_pkg::DUR_W-1:0]     duration;
    logic [mns_pkg::LENF_W-1:0]    length;

    modport source (
        output valid, action, melody_index, entry_index, note_code, duration, length,
        input  ready
    );
    modport sink (
        input  valid, action, melody_index, entry_index, note_code, duration, length,
        output ready
    );
endinterface

interface mns_res_if;
    logic                          valid;
    logic                          ready;
    logic                          note_valid;
    logic [mns_pkg::CODE_W-1:0]    note_out;
    logic [mns_pkg::PSTATE_W-1:0]  player_state;
    logic                          accepted;

    modport source (
        output valid, note_valid, note_out, player_state, accepted,
        input  ready
    );
    modport sink (
        input  valid, note_valid, note_out, player_state, accepted,
        output ready
    );
endinterface

`default_nettype wire

// File: hdl/melody_note_sequencer_top.sv
// Top level of the melody note sequencer: control sequencer, note store and register port.
//
//   channel  | direction | handshake        | contents
//   ---------+-----------+------------------+------------------------------------------
//   command  | in        | valid/ready      | action, melody/entry index, note, length
//   result   | out       | valid/ready      | note_valid, note_out, player_state, accepted
//   apb      | in/out    | psel/penable     | melody_count (0x0), ticks_per_unit (0x4)
//
// An item is accepted, executed and handed to the output register. A tick that
// fetches the next note adds a melody length lookup and a synchronous note store
// read, plus a step for every empty or finished melody passed over.
// The store has no reset and no clearing pass; it must be written before it is played.
// Melody lengths, the player state and the counters are cleared by rst_n at once.
// A finished result waits in the output register while the next item is accepted; the
// sequencer only stalls when a new result is ready and the output register is still full.
`default_nettype none

module melody_note_sequencer_top (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    mns_cmd_if.sink                            command,
    mns_res_if.source                          result,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [mns_pkg::PADDR_W-1:0]   paddr,
    input  wire logic [mns_pkg::PDATA_W-1:0]   pwdata,
    output logic      [mns_pkg::PDATA_W-1:0]   prdata,
    output logic                               pready
);

    // Sequencer and player state.
    mns_pkg::seq_state_t                state_reg, state_next;
    mns_pkg::run_state_t                run_state_reg, run_state_next;
    logic [mns_pkg::MPOS_W-1:0]         melody_pos_reg, melody_pos_next;
    logic [mns_pkg::NOTEP_W-1:0]        note_pos_reg, note_pos_next;
    logic [mns_pkg::TICK_W-1:0]         note_ticks_reg, note_ticks_next;
    logic [mns_pkg::TICK_W-1:0]         tick_count_reg, tick_count_next;
    logic [mns_pkg::LEN_W-1:0]          len_reg [mns_pkg::MAX_MELODIES];

    // Configuration registers.
    logic [mns_pkg::MCNT_W-1:0]         mel_count_reg;
    logic [mns_pkg::TPU_W-1:0]          tpu_reg;

    // Latched command.
    mns_pkg::action_t                   cmd_action_reg;
    logic [mns_pkg::MIDX_W-1:0]         cmd_mi_reg;
    logic [mns_pkg::EIDX_W-1:0]         cmd_ei_reg;
    logic [mns_pkg::CODE_W-1:0]         cmd_nc_reg;
    logic [mns_pkg::DUR_W-1:0]          cmd_du_reg;
    logic [mns_pkg::LENF_W-1:0]         cmd_ln_reg;

    // Result staged by the sequencer, then the output register.
    logic                               st_valid_reg, st_valid_next;
    logic [mns_pkg::CODE_W-1:0]         st_note_reg, st_note_next;
    logic                               st_acc_reg, st_acc_next;
    logic                               out_valid_reg;
    logic                               out_note_valid_reg;
    logic [mns_pkg::CODE_W-1:0]         out_note_reg;
    logic [mns_pkg::PSTATE_W-1:0]       out_pstate_reg;
    logic                               out_acc_reg;

    // Note store: entry is {note code, duration}.
    logic [15:0]                        store_mem [mns_pkg::DEPTH];
    logic [15:0]                        rd_data_reg;
    logic                               mem_we, mem_re;
    logic [mns_pkg::ADDR_W-1:0]         mem_waddr, mem_raddr;

    // Length write control.
    logic                               len_we;
    logic [mns_pkg::LEN_W-1:0]          len_wdata;

    logic                               cmd_fire;
    logic                               out_free;
    logic [mns_pkg::LEN_W-1:0]          cur_len;
    logic [mns_pkg::MPOS_W-1:0]         mpos_inc;
    logic [mns_pkg::TICK_W-1:0]         tick_inc;
    logic [mns_pkg::TICK_W-1:0]         gap_limit;
    logic [mns_pkg::TICK_W-1:0]         fetched_ticks;
    logic                               cfg_we;

    assign cmd_fire      = command.valid && command.ready;
    assign out_free      = !out_valid_reg || result.ready;
    assign command.ready = (state_reg == mns_pkg::SEQ_IDLE);

    assign tick_inc  = tick_count_reg + 1'b1;
    assign mpos_inc  = melody_pos_reg + 1'b1;
    assign gap_limit = mns_pkg::TICK_W'({tpu_reg, 1'b0});
    assign fetched_ticks = mns_pkg::TICK_W'(rd_data_reg[7:0] * tpu_reg);

    // Melodies beyond the store have no notes.
    always_comb
    begin
        if (32'(melody_pos_reg) >= mns_pkg::MAX_MELODIES) begin
            cur_len = '0;
        end else begin
            cur_len = len_reg[melody_pos_reg[mns_pkg::MEL_W-1:0]];
        end
    end

    // Next state of the sequencer.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            mns_pkg::SEQ_IDLE:
            begin
                if (cmd_fire) begin
                    state_next = mns_pkg::SEQ_EXEC;
                end
            end
            mns_pkg::SEQ_EXEC:
            begin
                if (cmd_action_reg == mns_pkg::ACT_TICK && run_state_reg == mns_pkg::RUN_PLAY
                    && !(note_ticks_reg > gap_limit && tick_count_reg == note_ticks_reg - 1'b1)
                    && tick_count_reg >= note_ticks_reg) begin
                    state_next = mns_pkg::SEQ_SEEK;
                end else begin
                    state_next = mns_pkg::SEQ_DONE;
                end
            end
            mns_pkg::SEQ_SEEK:
            begin
                if (32'(note_pos_reg) < 32'(cur_len)) begin
                    state_next = mns_pkg::SEQ_READ;
                end else if (mpos_inc >= mel_count_reg) begin
                    state_next = mns_pkg::SEQ_DONE;
                end
            end
            mns_pkg::SEQ_READ:
            begin
                state_next = mns_pkg::SEQ_DONE;
            end
            mns_pkg::SEQ_DONE:
            begin
                if (out_free) begin
                    state_next = mns_pkg::SEQ_IDLE;
                end
            end
            default:
            begin
                state_next = mns_pkg::SEQ_IDLE;
            end
        endcase
    end

    // Datapath and store controls for each sequencer state.
    always_comb
    begin
        run_state_next  = run_state_reg;
        melody_pos_next = melody_pos_reg;
        note_pos_next   = note_pos_reg;
        note_ticks_next = note_ticks_reg;
        tick_count_next = tick_count_reg;
        st_valid_next   = st_valid_reg;
        st_note_next    = st_note_reg;
        st_acc_next     = st_acc_reg;
        mem_we          = 1'b0;
        mem_waddr       = {cmd_mi_reg[mns_pkg::MEL_W-1:0], cmd_ei_reg[mns_pkg::NPOS_W-1:0]};
        mem_re          = 1'b0;
        mem_raddr       = {melody_pos_reg[mns_pkg::MEL_W-1:0],
                           note_pos_reg[mns_pkg::NPOS_W-1:0]};
        len_we          = 1'b0;
        len_wdata       = mns_pkg::LEN_W'(cmd_ln_reg);
        if (32'(cmd_ln_reg) > mns_pkg::NOTES_PER_MELODY) begin
            len_wdata = mns_pkg::LEN_W'(mns_pkg::NOTES_PER_MELODY);
        end

        unique case (state_reg)
            mns_pkg::SEQ_EXEC:
            begin
                st_valid_next = 1'b0;
                st_note_next  = mns_pkg::CODE_W'(mns_pkg::REST_CODE);
                st_acc_next   = 1'b0;
                unique case (cmd_action_reg)
                    mns_pkg::ACT_TICK:
                    begin
                        if (run_state_reg == mns_pkg::RUN_PLAY) begin
                            st_acc_next = 1'b1;
                            // A long note is cut one tick early by a rest.
                            if (note_ticks_reg > gap_limit
                                && tick_count_reg == note_ticks_reg - 1'b1) begin
                                st_valid_next   = 1'b1;
                                tick_count_next = tick_inc;
                            end else if (tick_count_reg >= note_ticks_reg) begin
                                tick_count_next = '0;
                            end else begin
                                tick_count_next = tick_inc;
                            end
                        end
                    end
                    mns_pkg::ACT_PLAY:
                    begin
                        st_acc_next     = 1'b1;
                        melody_pos_next = '0;
                        note_pos_next   = '0;
                        note_ticks_next = '0;
                        tick_count_next = '0;
                        run_state_next  = mns_pkg::RUN_PLAY;
                    end
                    mns_pkg::ACT_STOP:
                    begin
                        st_acc_next    = 1'b1;
                        st_valid_next  = 1'b1;
                        run_state_next = mns_pkg::RUN_STOP;
                    end
                    mns_pkg::ACT_PAUSE:
                    begin
                        if (run_state_reg == mns_pkg::RUN_PLAY) begin
                            st_acc_next    = 1'b1;
                            st_valid_next  = 1'b1;
                            run_state_next = mns_pkg::RUN_PAUSE;
                        end
                    end
                    mns_pkg::ACT_RESUME:
                    begin
                        if (run_state_reg == mns_pkg::RUN_PAUSE) begin
                            st_acc_next    = 1'b1;
                            run_state_next = mns_pkg::RUN_PLAY;
                        end
                    end
                    mns_pkg::ACT_WR_NOTE:
                    begin
                        if (32'(cmd_mi_reg) < mns_pkg::MAX_MELODIES
                            && 32'(cmd_ei_reg) < mns_pkg::NOTES_PER_MELODY) begin
                            st_acc_next = 1'b1;
                            mem_we      = 1'b1;
                        end
                    end
                    mns_pkg::ACT_WR_LENGTH:
                    begin
                        if (32'(cmd_mi_reg) < mns_pkg::MAX_MELODIES) begin
                            st_acc_next = 1'b1;
                            len_we      = 1'b1;
                        end
                    end
                    default:
                    begin
                        st_acc_next = 1'b0;
                    end
                endcase
            end
            mns_pkg::SEQ_SEEK:
            begin
                if (32'(note_pos_reg) < 32'(cur_len)) begin
                    mem_re = 1'b1;
                end else begin
                    melody_pos_next = mpos_inc;
                    note_pos_next   = '0;
                    if (mpos_inc >= mel_count_reg) begin
                        // Past the last melody: stop with a rest; the tick count stays cleared.
                        run_state_next  = mns_pkg::RUN_STOP;
                        st_valid_next   = 1'b1;
                    end
                end
            end
            mns_pkg::SEQ_READ:
            begin
                st_valid_next   = 1'b1;
                st_note_next    = rd_data_reg[15:8];
                note_ticks_next = fetched_ticks;
                note_pos_next   = note_pos_reg + 1'b1;
                tick_count_next = tick_inc;
            end
            mns_pkg::SEQ_IDLE,
            mns_pkg::SEQ_DONE:
            begin
                mem_re = 1'b0;
            end
            default:
            begin
                mem_re = 1'b0;
            end
        endcase
    end

    // Note store, written and read in one clocked block.
    always_ff @(posedge clk)
    begin
        if (mem_we) begin
            store_mem[mem_waddr] <= {cmd_nc_reg, cmd_du_reg};
        end
        if (mem_re) begin
            rd_data_reg <= store_mem[mem_raddr];
        end
    end

    // Command latch, staged result and output register payload; payload needs no reset.
    always_ff @(posedge clk)
    begin
        if (cmd_fire) begin
            cmd_action_reg <= mns_pkg::action_t'(command.action);
            cmd_mi_reg     <= command.melody_index;
            cmd_ei_reg     <= command.entry_index;
            cmd_nc_reg     <= command.note_code;
            cmd_du_reg     <= command.duration;
            cmd_ln_reg     <= command.length;
        end
        st_valid_reg <= st_valid_next;
        st_note_reg  <= st_note_next;
        st_acc_reg   <= st_acc_next;
        if (state_reg == mns_pkg::SEQ_DONE && out_free) begin
            out_note_valid_reg <= st_valid_reg;
            out_note_reg       <= st_note_reg;
            out_pstate_reg     <= run_state_reg;
            out_acc_reg        <= st_acc_reg;
        end
    end

    // Control state, player counters, output valid flag and lengths.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg      <= mns_pkg::SEQ_IDLE;
            run_state_reg  <= mns_pkg::RUN_STOP;
            melody_pos_reg <= '0;
            note_pos_reg   <= '0;
            note_ticks_reg <= '0;
            tick_count_reg <= '0;
            out_valid_reg  <= 1'b0;
            for (int i = 0; i < mns_pkg::MAX_MELODIES; i++) begin
                len_reg[i] <= '0;
            end
        end else begin
            state_reg      <= state_next;
            run_state_reg  <= run_state_next;
            melody_pos_reg <= melody_pos_next;
            note_pos_reg   <= note_pos_next;
            note_ticks_reg <= note_ticks_next;
            tick_count_reg <= tick_count_next;
            if (state_reg == mns_pkg::SEQ_DONE && out_free) begin
                out_valid_reg <= 1'b1;
            end else if (result.ready) begin
                out_valid_reg <= 1'b0;
            end
            if (len_we) begin
                len_reg[cmd_mi_reg[mns_pkg::MEL_W-1:0]] <= len_wdata;
            end
        end
    end

    assign result.valid        = out_valid_reg;
    assign result.note_valid   = out_note_valid_reg;
    assign result.note_out     = out_note_reg;
    assign result.player_state = out_pstate_reg;
    assign result.accepted     = out_acc_reg;

    // Register port; the register is chosen by address bit 2 alone.
    assign pready = 1'b1;
    assign cfg_we = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            mel_count_reg <= mns_pkg::MCNT_W'(1);
            tpu_reg       <= mns_pkg::TPU_W'(10);
        end else if (cfg_we) begin
            unique case (mns_pkg::reg_index_t'(paddr[2]))
                mns_pkg::REG_MELODY_COUNT:   mel_count_reg <= pwdata[mns_pkg::MCNT_W-1:0];
                mns_pkg::REG_TICKS_PER_UNIT: tpu_reg       <= pwdata[mns_pkg::TPU_W-1:0];
                default:                     tpu_reg       <= tpu_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (mns_pkg::reg_index_t'(paddr[2]))
            mns_pkg::REG_MELODY_COUNT:   prdata = mns_pkg::PDATA_W'(mel_count_reg);
            mns_pkg::REG_TICKS_PER_UNIT: prdata = mns_pkg::PDATA_W'(tpu_reg);
            default:                     prdata = '0;
        endcase
    end

endmodule

`default_nettype wire

// File: tb/melody_note_sequencer_checker.sv
// Checker for the melody note sequencer: predicts the response to each command and compares.
`timescale 1ns / 100ps

module melody_note_sequencer_checker
    import mns_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    mns_cmd_if                 command,
    mns_res_if                 result,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic               pready,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output int                 errors,
    output int                 outstanding,
    output int                 notes_driven
);

    typedef struct packed {
        logic              note_valid;
        logic [CODE_W-1:0] note;
        run_state_t        pstate;
        logic              accepted;
    } response_t;

    // Predicted player state and its own copy of the registers.
    logic [MCNT_W-1:0]  mel_count;
    logic [TPU_W-1:0]   tpu;
    run_state_t         run;
    logic [MPOS_W-1:0]  mel_pos;
    logic [NOTEP_W-1:0] note_pos;
    logic [TICK_W-1:0]  note_ticks;
    logic [TICK_W-1:0]  tick_cnt;
    logic [15:0]        note_store [DEPTH];
    logic [LEN_W-1:0]   mel_len [MAX_MELODIES];

    response_t responses [$];
    int        results_seen;

    // Melodies past the end of the store always count as empty.
    function automatic logic [LEN_W-1:0] melody_length(input logic [MPOS_W-1:0] m);
        if (int'(m) >= MAX_MELODIES)
            return '0;
        return mel_len[m[MEL_W-1:0]];
    endfunction

    // Advances note time by one tick; returns 1 when a note or a rest goes out.
    function automatic logic tick_player(output logic [CODE_W-1:0] note);
        logic [15:0] entry;
        logic        drove;
        drove = 1'b0;
        note = CODE_W'(REST_CODE);
        if (int'(note_ticks) > 2 * int'(tpu) && tick_cnt == note_ticks - 1'b1)
        begin
            // Gap rest on the last tick of a long note.
            drove = 1'b1;
        end
        else if (tick_cnt >= note_ticks)
        begin
            tick_cnt = '0;
            for (int k = 0; k < 32; k++)
            begin
                if (note_pos >= melody_length(mel_pos))
                begin
                    mel_pos = mel_pos + 1'b1;
                    note_pos = '0;
                    if (mel_pos >= mel_count)
                    begin
                        // End of the tune; the tick counter is left as it is.
                        run = RUN_STOP;
                        return 1'b1;
                    end
                end
                else
                begin
                    entry = note_store[int'(mel_pos) * NOTES_PER_MELODY + int'(note_pos)];
                    note = entry[15:8];
                    note_ticks = TICK_W'(int'(entry[7:0]) * int'(tpu));
                    note_pos = note_pos + 1'b1;
                    drove = 1'b1;
                    break;
                end
            end
        end
        tick_cnt = tick_cnt + 1'b1;
        return drove;
    endfunction

    function automatic response_t sequencer_step(
        input logic [ACTION_W-1:0] act,
        input logic [MIDX_W-1:0]   mi,
        input logic [EIDX_W-1:0]   ei,
        input logic [CODE_W-1:0]   nc,
        input logic [DUR_W-1:0]    du,
        input logic [LENF_W-1:0]   ln
    );
        response_t         r;
        logic [CODE_W-1:0] n;
        r.note_valid = 1'b0;
        r.note = CODE_W'(REST_CODE);
        r.accepted = 1'b0;
        case (act)
            ACT_TICK:
            begin
                if (run == RUN_PLAY)
                begin
                    r.accepted = 1'b1;
                    r.note_valid = tick_player(n);
                    r.note = n;
                end
            end
            ACT_PLAY:
            begin
                r.accepted = 1'b1;
                mel_pos = '0;
                note_pos = '0;
                note_ticks = '0;
                tick_cnt = '0;
                run = RUN_PLAY;
            end
            ACT_STOP:
            begin
                r.accepted = 1'b1;
                r.note_valid = 1'b1;
                run = RUN_STOP;
            end
            ACT_PAUSE:
            begin
                if (run == RUN_PLAY)
                begin
                    r.accepted = 1'b1;
                    r.note_valid = 1'b1;
                    run = RUN_PAUSE;
                end
            end
            ACT_RESUME:
            begin
                if (run == RUN_PAUSE)
                begin
                    r.accepted = 1'b1;
                    run = RUN_PLAY;
                end
            end
            ACT_WR_NOTE:
            begin
                if (int'(mi) < MAX_MELODIES && int'(ei) < NOTES_PER_MELODY)
                begin
                    note_store[int'(mi) * NOTES_PER_MELODY + int'(ei)] = {nc, du};
                    r.accepted = 1'b1;
                end
            end
            ACT_WR_LENGTH:
            begin
                if (int'(mi) < MAX_MELODIES)
                begin
                    mel_len[mi] = (int'(ln) > NOTES_PER_MELODY) ? LEN_W'(NOTES_PER_MELODY)
                                                               : LEN_W'(ln);
                    r.accepted = 1'b1;
                end
            end
            default:
            begin
            end
        endcase
        r.pstate = run;
        return r;
    endfunction

    task automatic report_mismatch(input string what);
        $display("[%0t] mismatch on result %0d: %s", $time, results_seen, what);
        errors++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        response_t want;
        response_t got;
        if (!rst_n)
        begin
            mel_count = MCNT_W'(1);
            tpu = TPU_W'(10);
            run = RUN_STOP;
            mel_pos = '0;
            note_pos = '0;
            note_ticks = '0;
            tick_cnt = '0;
            for (int m = 0; m < MAX_MELODIES; m++)
                mel_len[m] = '0;
            responses.delete();
            results_seen = 0;
            errors = 0;
            outstanding = 0;
            notes_driven = 0;
        end
        else
        begin
            if (psel && penable && pwrite && pready)
            begin
                case (paddr[PADDR_W-1:2])
                    REG_MELODY_COUNT:   mel_count = pwdata[MCNT_W-1:0];
                    REG_TICKS_PER_UNIT: tpu = pwdata[TPU_W-1:0];
                    default:
                    begin
                    end
                endcase
            end
            if (command.valid && command.ready)
                responses.push_back(sequencer_step(command.action, command.melody_index,
                    command.entry_index, command.note_code, command.duration, command.length));
            if (result.valid && result.ready)
            begin
                got.note_valid = result.note_valid;
                got.note = result.note_out;
                got.pstate = run_state_t'(result.player_state);
                got.accepted = result.accepted;
                if (responses.size() == 0)
                    report_mismatch("result with no command waiting for it");
                else
                begin
                    want = responses.pop_front();
                    if (got.note_valid !== want.note_valid)
                        report_mismatch($sformatf("note_valid %0b, expected %0b",
                            got.note_valid, want.note_valid));
                    if (got.note !== want.note)
                        report_mismatch($sformatf("note_out %0h, expected %0h",
                            got.note, want.note));
                    if (got.pstate !== want.pstate)
                        report_mismatch($sformatf("player_state %0d, expected %0d",
                            got.pstate, want.pstate));
                    if (got.accepted !== want.accepted)
                        report_mismatch($sformatf("accepted %0b, expected %0b",
                            got.accepted, want.accepted));
                end
                if (result.note_valid === 1'b1)
                    notes_driven++;
                results_seen++;
            end
            outstanding = responses.size();
        end
    end

endmodule

// File: tb/melody_note_sequencer_top_tb.sv
// Testbench top of the melody note sequencer: stimulus, register writes and the verdict.
`timescale 1ns / 100ps

module melody_note_sequencer_top_tb;
    import mns_pkg::*;

    // Action code that the sequencer does not define; it must be ignored.
    localparam logic [ACTION_W-1:0] ACT_UNUSED = 3'd7;
    // Longest length value the field can carry; it saturates to a full melody.
    localparam int LEN_MAX   = (1 << LENF_W) - 1;
    // Cycles to let pass once nothing is expected: item, store read and melody skips.
    localparam int SETTLE    = 16;
    // Length of the one long hold-off on the result side.
    localparam int LONG_HOLD = 300;
    // Hard stop of the run, several times the slowest legal run.
    localparam int LIMIT_NS  = 5_000_000;

    logic               clk;
    logic               rst_n;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [PDATA_W-1:0] pwdata;
    logic [PDATA_W-1:0] prdata;
    logic               pready;

    int errors;
    int outstanding;
    int notes_driven;

    mns_cmd_if command ();
    mns_res_if result ();

    // Generator bookkeeping. The store has no reset, so the generator tracks which
    // entries hold a note and never lets a melody length reach past the filled prefix.
    bit written [MAX_MELODIES][NOTES_PER_MELODY];
    int filled [MAX_MELODIES];
    int items_sent;
    int settings_used;

    // Idling: one burst in gap_odds before an item, one stall burst in stall_odds
    // cycles on the result side; zero turns that side's idling off.
    int gap_odds;
    int stall_odds;
    int holds_asked;

    // Register settings of the random phases, extremes included. A count of zero and a
    // count equal to the store size are both legal register values and both get used.
    int tune_counts [8] = '{8, 3, 0, 8, 2, 6, 1, 8};
    int tune_tpus [8]   = '{1, 2, 3, 0, 1023, 5, 1, 2};

    melody_note_sequencer_top DUT (
        .clk     (clk),
        .rst_n   (rst_n),
        .command (command),
        .result  (result),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    melody_note_sequencer_checker response_check (
        .clk          (clk),
        .rst_n        (rst_n),
        .command      (command),
        .result       (result),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .pready       (pready),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .errors       (errors),
        .outstanding  (outstanding),
        .notes_driven (notes_driven)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Offers one item at a falling edge, optionally after an idle burst, and returns
    // at the rising edge where the block takes it. Valid stays high afterwards so that
    // back-to-back items are offered without a gap.
    task automatic issue(
        input logic [ACTION_W-1:0] act,
        input logic [MIDX_W-1:0]   mi,
        input logic [EIDX_W-1:0]   ei,
        input logic [CODE_W-1:0]   nc,
        input logic [DUR_W-1:0]    du,
        input logic [LENF_W-1:0]   ln
    );
        int gap;
        if (gap_odds != 0 && $urandom_range(1, gap_odds) == 1)
        begin
            gap = $urandom_range(1, 15);
            @(negedge clk);
            command.valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        command.valid        <= 1'b1;
        command.action       <= act;
        command.melody_index <= mi;
        command.entry_index  <= ei;
        command.note_code    <= nc;
        command.duration     <= du;
        command.length       <= ln;
        @(posedge clk);
        while (!command.ready)
            @(posedge clk);
        items_sent++;
    endtask

    // Player command; the fields it does not use carry random bits.
    task automatic control(input logic [ACTION_W-1:0] act);
        issue(act, MIDX_W'($urandom_range(0, 7)), EIDX_W'($urandom_range(0, 255)),
              CODE_W'($urandom_range(0, 255)), DUR_W'($urandom_range(0, 255)),
              LENF_W'($urandom_range(0, LEN_MAX)));
    endtask

    task automatic store_note(input int m, input int e, input int nc, input int du);
        issue(ACT_WR_NOTE, MIDX_W'(m), EIDX_W'(e), CODE_W'(nc), DUR_W'(du),
              LENF_W'($urandom_range(0, LEN_MAX)));
        written[m][e] = 1'b1;
        while (filled[m] < NOTES_PER_MELODY && written[m][filled[m]])
            filled[m]++;
    endtask

    task automatic set_length(input int m, input int ln);
        issue(ACT_WR_LENGTH, MIDX_W'(m), EIDX_W'($urandom_range(0, 255)),
              CODE_W'($urandom_range(0, 255)), DUR_W'($urandom_range(0, 255)), LENF_W'(ln));
    endtask

    // A length that only covers written entries; a full melody may take any value,
    // including the ones that saturate.
    function automatic int pick_length(input int m);
        if (filled[m] == NOTES_PER_MELODY && $urandom_range(0, 3) == 0)
            return $urandom_range(NOTES_PER_MELODY, LEN_MAX);
        if ($urandom_range(0, 1) == 0)
            return filled[m];
        return $urandom_range(0, filled[m]);
    endfunction

    // Mostly short notes so that melodies actually advance; now and then any duration.
    function automatic int pick_duration();
        if ($urandom_range(0, 15) == 0)
            return $urandom_range(0, 255);
        return $urandom_range(0, 3);
    endfunction

    function automatic int pick_odds();
        case ($urandom_range(0, 2))
            0:       return 0;
            1:       return 4;
            default: return 12;
        endcase
    endfunction

    // Extends a melody by a few notes and then sets its length.
    task automatic load_melody(input int m, input int count);
        for (int k = 0; k < count && filled[m] < NOTES_PER_MELODY; k++)
            store_note(m, filled[m], $urandom_range(0, 255), pick_duration());
        set_length(m, pick_length(m));
    endtask

    // Play from the top and tick along, with pauses, restarts and a final stop now and then.
    task automatic play_run(input int ticks);
        control(ACT_PLAY);
        for (int k = 0; k < ticks; k++)
        begin
            case ($urandom_range(0, 19))
                0:
                begin
                    control(ACT_PAUSE);
                    repeat ($urandom_range(0, 2)) control(ACT_TICK);
                    control(ACT_RESUME);
                end
                1:       control(ACT_PLAY);
                default: control(ACT_TICK);
            endcase
        end
        if ($urandom_range(0, 2) != 0)
            control(ACT_STOP);
    endtask

    // Any action at all; store writes go to any entry, lengths kept within what has been filled.
    task automatic noise(input int count);
        logic [ACTION_W-1:0] act;
        int                  m;
        for (int k = 0; k < count; k++)
        begin
            act = ACTION_W'($urandom_range(0, 7));
            m = $urandom_range(0, MAX_MELODIES - 1);
            if (act == ACT_WR_LENGTH)
                set_length(m, pick_length(m));
            else if (act == ACT_WR_NOTE)
                store_note(m, $urandom_range(0, 255), $urandom_range(0, 255), pick_duration());
            else
                control(act);
        end
    endtask

    task automatic random_phase(input int target);
        int start;
        start = items_sent;
        while (items_sent - start < target)
        begin
            case ($urandom_range(0, 7))
                0, 1:       load_melody($urandom_range(0, MAX_MELODIES - 1), $urandom_range(1, 6));
                2, 3, 4, 5: play_run($urandom_range(8, 40));
                default:    noise($urandom_range(1, 5));
            endcase
        end
    endtask

    // Setup cycle, then access cycle; the register takes the value at the rising edge
    // of the access cycle once pready is high.
    task automatic reg_write(input reg_index_t idx, input int value);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= PADDR_W'(int'(idx) * 4);
        pwdata  <= PDATA_W'(value);
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // Stops offering items and waits until every expected result is out and the
    // block has had time to finish any melody skip still in flight.
    task automatic quiesce();
        @(negedge clk);
        command.valid <= 1'b0;
        while (outstanding != 0)
            @(negedge clk);
        repeat (SETTLE) @(negedge clk);
    endtask

    task automatic retune(input int count, input int ticks_per_unit);
        quiesce();
        reg_write(REG_MELODY_COUNT, count);
        reg_write(REG_TICKS_PER_UNIT, ticks_per_unit);
        settings_used++;
    endtask

    // Result side: random stall bursts, plus one long hold-off on request during which
    // the sender keeps offering items, so the block fills up and stalls its input.
    initial
    begin
        int hold;
        int holds_done;
        hold = 0;
        holds_done = 0;
        result.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold > 0)
            begin
                hold--;
                result.ready <= 1'b0;
            end
            else if (holds_done < holds_asked)
            begin
                holds_done++;
                hold = LONG_HOLD - 1;
                result.ready <= 1'b0;
            end
            else if (stall_odds != 0 && $urandom_range(1, stall_odds) == 1)
            begin
                hold = $urandom_range(1, 15) - 1;
                result.ready <= 1'b0;
            end
            else
                result.ready <= 1'b1;
        end
    end

    initial
    begin
        rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        command.valid = 1'b0;
        command.action = '0;
        command.melody_index = '0;
        command.entry_index = '0;
        command.note_code = '0;
        command.duration = '0;
        command.length = '0;
        items_sent = 0;
        settings_used = 0;
        holds_asked = 0;
        gap_odds = 6;
        stall_odds = 6;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed part under the reset register values (one melody, ten ticks a unit).
        // Commands that make no sense while stopped are ignored; stop always drives a rest.
        control(ACT_TICK);
        control(ACT_PAUSE);
        control(ACT_RESUME);
        control(ACT_UNUSED);
        control(ACT_STOP);
        // Extreme codes and indexes. Zero durations make each note last a single tick.
        store_note(0, 0, 255, 0);
        store_note(0, 1, 0, 0);
        store_note(MAX_MELODIES - 1, NOTES_PER_MELODY - 1, 8'hAA, 255);
        set_length(0, 2);
        set_length(3, 0);
        // Both notes, then the end of the tune stops the player with a rest.
        control(ACT_PLAY);
        repeat (3) control(ACT_TICK);
        // Pause drives a rest; ticks and a second pause are ignored until resume.
        control(ACT_PLAY);
        control(ACT_PAUSE);
        control(ACT_TICK);
        control(ACT_PAUSE);
        control(ACT_RESUME);
        control(ACT_TICK);
        // Play while playing restarts from the first melody.
        control(ACT_PLAY);
        control(ACT_STOP);

        // Fill the last melody completely, empty all the others and give it a length
        // that saturates. With a melody count past the store size, playing it skips the
        // empty melodies, runs every note to the end and then skips the melodies beyond
        // the store. Durations of three units make the gap rest show up.
        retune(15, 1);
        for (int e = 0; e < NOTES_PER_MELODY; e++)
            store_note(MAX_MELODIES - 1, e, $urandom_range(0, 255),
                       ($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0);
        for (int m = 0; m < MAX_MELODIES - 1; m++)
            set_length(m, 0);
        set_length(MAX_MELODIES - 1, LEN_MAX);
        control(ACT_PLAY);
        repeat (360) control(ACT_TICK);
        control(ACT_STOP);

        // Random phases, one per register setting. The first one carries the long
        // hold-off; the last one runs with no idling on either side.
        for (int p = 0; p < 8; p++)
        begin
            retune(tune_counts[p], tune_tpus[p]);
            gap_odds = pick_odds();
            stall_odds = pick_odds();
            if (p == 7)
            begin
                gap_odds = 0;
                stall_odds = 0;
            end
            if (p == 0)
                holds_asked++;
            random_phase(110);
        end

        quiesce();
        $display("Run covered %0d commands under %0d register settings, long notes, pauses,",
                 items_sent, settings_used);
        $display("restarts, empty melodies and end of tune; %0d notes and rests driven.",
                 notes_driven);
        if (errors == 0 && outstanding == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    // Hard limit in case the block hangs or a result never comes.
    initial
    begin
        #(LIMIT_NS);
        $display("tb: failure");
        $finish;
    end

endmodule
